// ===== sv/sphere_brush_sdf_falloff_unit_assert.svh =====
// Assertion macros used by the checker of the sphere brush falloff unit.
// Each macro expands to one labeled concurrent assertion clocked on aclk.
`ifndef SPHERE_BRUSH_SDF_FALLOFF_UNIT_ASSERT_SVH
`define SPHERE_BRUSH_SDF_FALLOFF_UNIT_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define SBSDF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion that is also checked during reset.
`define SBSDF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/sbsdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbsdf_pkg
// Types and constants of the sphere brush SDF falloff unit.
// ----------------------------------------------------------------------------
package sbsdf_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    // Register map of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER_X       = 8'd0,
        REG_CENTER_Y       = 8'd1,
        REG_CENTER_Z       = 8'd2,
        REG_BRUSH_RADIUS   = 8'd3,
        REG_FALLOFF_WIDTH  = 8'd4,
        REG_BRUSH_STRENGTH = 8'd5,
        REG_DIG_MODE       = 8'd6,
        REG_VOXEL_SIZE     = 8'd7
    } cfg_reg_e;

    // Levels in Q1.14.
    localparam logic signed [16:0] AIR_LEVEL   = 17'sd16384;
    localparam logic signed [16:0] SOLID_LEVEL = -17'sd16384;
    localparam logic signed [20:0] SDF_MAX     = 21'sd16384;
    localparam logic signed [20:0] SDF_MIN     = -21'sd16384;
    localparam logic signed [20:0] SDF_THRESH  = 21'sd163;
    localparam logic [14:0]        T_ONE       = 15'd16384;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [23:0] terrain_height;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sdf_value;
        logic               in_bounds;
    } out_item_t;

    // Per-item flags carried down the pipeline.
    typedef struct packed {
        logic below;
        logic inb;
        logic inner;
    } flags_t;

endpackage
`default_nettype wire

// ===== sv/sphere_brush_sdf_falloff_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_brush_sdf_falloff_unit
// Fully pipelined sphere brush SDF with smoothstep falloff band.
// ----------------------------------------------------------------------------
// Usage:
// s_valid/s_ready take one voxel item per cycle (position and terrain height) while s_ready is high.
// m_valid/m_ready return one result item (sdf_value, in_bounds) per input
// item, in order. cfg_valid/cfg_ready write register cfg_index with cfg_data;
// cfg_ready is always high, indexes above 7 are ignored, and registers may
// only change while no item is in flight.
// The item passes 61 register stages; throughput is one item per cycle as long
// as the receiver does not stall. The depth is set by the square root (one root
// bit per stage, 32 stages) and the band division (one quotient bit per stage,
// 14 stages).
// A two-entry output buffer keeps the pipeline moving while one result waits;
// when the receiver stalls longer, the whole pipeline holds and s_ready drops
// until the spare entry drains. Nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// register defaults: center 0, radius 1.0, falloff 1.0, strength 1.0, dig
// mode, voxel size 1.0.
// ----------------------------------------------------------------------------
module sphere_brush_sdf_falloff_unit
    import sbsdf_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_item_t               s_item,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_item_t                   m_item,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SQ_N = 32;
    localparam int DV_N = 14;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [23:0] cx_reg, cy_reg, cz_reg;
    logic [22:0]        radius_reg, falloff_reg;
    logic [15:0]        strength_reg, voxel_reg;
    logic               dig_reg;
    logic [45:0]        rad_sq_reg;
    logic [24:0]        outer_reg;
    logic [49:0]        outer_sq_reg;
    logic [23:0]        fade_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg       <= '0;
            cy_reg       <= '0;
            cz_reg       <= '0;
            radius_reg   <= 23'd256;
            falloff_reg  <= 23'd256;
            strength_reg <= 16'd16384;
            dig_reg      <= 1'b1;
            voxel_reg    <= 16'd256;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTER_X:       cx_reg       <= cfg_data;
                REG_CENTER_Y:       cy_reg       <= cfg_data;
                REG_CENTER_Z:       cz_reg       <= cfg_data;
                REG_BRUSH_RADIUS:   radius_reg   <= cfg_data[22:0];
                REG_FALLOFF_WIDTH:  falloff_reg  <= cfg_data[22:0];
                REG_BRUSH_STRENGTH: strength_reg <= cfg_data[15:0];
                REG_DIG_MODE:       dig_reg      <= cfg_data[0];
                REG_VOXEL_SIZE:     voxel_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Derived values, registered one after another (fade, outer, squares); they
    // settle well before an item gets to the stages that use them.
    always_ff @(posedge aclk) begin
        fade_reg     <= 24'(falloff_reg) + 24'(voxel_reg);
        outer_reg    <= 25'(radius_reg) + 25'(fade_reg);
        rad_sq_reg   <= radius_reg * radius_reg;
        outer_sq_reg <= outer_reg * outer_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline enable and output buffer
    // ------------------------------------------------------------------
    logic      en;
    logic      push;
    logic      pop;
    logic      skid_v_reg;
    out_item_t skid_reg;
    out_item_t out_reg;
    logic      out_v_reg;
    out_item_t res_item;
    logic      r_v_reg;

    assign en      = !skid_v_reg;
    assign s_ready = en;
    assign push    = en && r_v_reg;
    assign pop     = out_v_reg && m_ready;
    assign m_valid = out_v_reg;
    assign m_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (!out_v_reg || pop) begin
                if (skid_v_reg) begin
                    out_v_reg  <= 1'b1;
                    skid_v_reg <= push;
                end else begin
                    out_v_reg <= push;
                end
            end else if (push) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || pop) begin
            if (skid_v_reg) begin
                out_reg <= skid_reg;
                if (push) begin
                    skid_reg <= res_item;
                end
            end else if (push) begin
                out_reg <= res_item;
            end
        end else if (push) begin
            skid_reg <= res_item;
        end
    end

    // Round p / 2^14 half away from zero.
    function automatic logic signed [20:0] rnd14(input logic signed [33:0] p);
        logic [33:0] m;
        logic [19:0] q;
        m = p[33] ? 34'(-p) : 34'(p);
        q = 20'((m + 34'd8192) >> 14);
        return p[33] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // ------------------------------------------------------------------
    // Stage 1: absolute differences
    // ------------------------------------------------------------------
    logic               s1_v_reg;
    logic [24:0]        s1_ax_reg, s1_ay_reg, s1_az_reg;
    logic               s1_below_reg;
    logic signed [24:0] dx, dy, dz;

    assign dx = {s_item.pos_x[23], s_item.pos_x} - {cx_reg[23], cx_reg};
    assign dy = {s_item.pos_y[23], s_item.pos_y} - {cy_reg[23], cy_reg};
    assign dz = {s_item.pos_z[23], s_item.pos_z} - {cz_reg[23], cz_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ax_reg    <= dx[24] ? 25'(-dx) : 25'(dx);
            s1_ay_reg    <= dy[24] ? 25'(-dy) : 25'(dy);
            s1_az_reg    <= dz[24] ? 25'(-dz) : 25'(dz);
            s1_below_reg <= s_item.pos_z < s_item.terrain_height;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares; stage 3: sum
    // ------------------------------------------------------------------
    logic        s2_v_reg, s3_v_reg;
    logic [49:0] s2_qx_reg, s2_qy_reg, s2_qz_reg;
    logic        s2_below_reg, s3_below_reg;
    logic [51:0] s3_d2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end else if (en) begin
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_qx_reg    <= s1_ax_reg * s1_ax_reg;
            s2_qy_reg    <= s1_ay_reg * s1_ay_reg;
            s2_qz_reg    <= s1_az_reg * s1_az_reg;
            s2_below_reg <= s1_below_reg;
            s3_d2_reg    <= 52'(s2_qx_reg) + 52'(s2_qy_reg) + 52'(s2_qz_reg);
            s3_below_reg <= s2_below_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root of d2 * 4096, one root bit per stage
    // ------------------------------------------------------------------
    logic        sq_v_reg    [0:SQ_N];
    logic [34:0] sq_rem_reg  [0:SQ_N];
    logic [31:0] sq_root_reg [0:SQ_N];
    logic [51:0] sq_d2_reg   [0:SQ_N];
    flags_t      sq_fl_reg   [0:SQ_N];

    // Entry stage: bounds tests.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= s3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg[0]      <= '0;
            sq_root_reg[0]     <= '0;
            sq_d2_reg[0]       <= s3_d2_reg;
            sq_fl_reg[0].below <= s3_below_reg;
            sq_fl_reg[0].inb   <= s3_d2_reg <= 52'(outer_sq_reg);
            sq_fl_reg[0].inner <= s3_d2_reg <= 52'(rad_sq_reg);
        end
    end

    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        localparam int I = SQ_N - 1 - j;
        logic [63:0] xf;
        logic [34:0] r2;
        logic [34:0] trial;
        logic        ge;

        assign xf    = {sq_d2_reg[j], 12'd0};
        assign r2    = {sq_rem_reg[j][32:0], xf[2*I+1:2*I]};
        assign trial = {1'b0, sq_root_reg[j], 2'b01};
        assign ge    = r2 >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[j+1] <= 1'b0;
            end else if (en) begin
                sq_v_reg[j+1] <= sq_v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[j+1]  <= ge ? r2 - trial : r2;
                sq_root_reg[j+1] <= {sq_root_reg[j][30:0], ge};
                sq_d2_reg[j+1]   <= sq_d2_reg[j];
                sq_fl_reg[j+1]   <= sq_fl_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Band numerator, then saturation test and division setup
    // ------------------------------------------------------------------
    logic        na_v_reg;
    logic [31:0] na_num_reg;
    flags_t      na_fl_reg;
    logic [31:0] root_dist;
    logic [31:0] r14;

    assign root_dist = sq_root_reg[SQ_N];
    assign r14       = {3'd0, radius_reg, 6'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            na_v_reg <= 1'b0;
        end else if (en) begin
            na_v_reg <= sq_v_reg[SQ_N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            na_num_reg <= (root_dist > r14) ? root_dist - r14 : '0;
            na_fl_reg  <= sq_fl_reg[SQ_N];
        end
    end

    // Quotient of (num << 8) / fade; t saturates at one when num >= 64*fade,
    // which also covers a zero fade range.
    logic        dv_v_reg   [0:DV_N];
    logic [39:0] dv_rem_reg [0:DV_N];
    logic [13:0] dv_q_reg   [0:DV_N];
    logic        dv_sat_reg [0:DV_N];
    flags_t      dv_fl_reg  [0:DV_N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= na_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0] <= {na_num_reg, 8'd0};
            dv_q_reg[0]   <= '0;
            dv_sat_reg[0] <= 40'(na_num_reg) >= {10'd0, fade_reg, 6'd0};
            dv_fl_reg[0]  <= na_fl_reg;
        end
    end

    for (genvar k = 0; k < DV_N; k++) begin : g_div
        localparam int I = DV_N - 1 - k;
        logic [39:0] trial;
        logic        ge;
        logic [13:0] q_next;

        assign trial = 40'(fade_reg) << I;
        assign ge    = !dv_sat_reg[k] && (dv_rem_reg[k] >= trial);

        always_comb begin
            q_next    = dv_q_reg[k];
            q_next[I] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[k+1] <= ge ? dv_rem_reg[k] - trial : dv_rem_reg[k];
                dv_q_reg[k+1]   <= q_next;
                dv_sat_reg[k+1] <= dv_sat_reg[k];
                dv_fl_reg[k+1]  <= dv_fl_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Smoothstep s = round(t*t*(3 - 2t)) in Q1.14
    // ------------------------------------------------------------------
    logic        t_v_reg, m1_v_reg, m2_v_reg, ss_v_reg;
    logic [14:0] t_reg;
    logic [29:0] m1_tt_reg;
    logic [15:0] m1_w_reg;
    logic [45:0] m2_p_reg;
    logic [14:0] ss_s_reg;
    flags_t      t_fl_reg, m1_fl_reg, m2_fl_reg, ss_fl_reg;
    logic [45:0] p_rnd;

    assign p_rnd = m2_p_reg + 46'(1) * (46'd1 << 27);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_v_reg  <= 1'b0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            ss_v_reg <= 1'b0;
        end else if (en) begin
            t_v_reg  <= dv_v_reg[DV_N];
            m1_v_reg <= t_v_reg;
            m2_v_reg <= m1_v_reg;
            ss_v_reg <= m2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg     <= dv_sat_reg[DV_N] ? T_ONE : {1'b0, dv_q_reg[DV_N]};
            t_fl_reg  <= dv_fl_reg[DV_N];
            m1_tt_reg <= t_reg * t_reg;
            m1_w_reg  <= 16'd49152 - {t_reg, 1'b0};
            m1_fl_reg <= t_fl_reg;
            m2_p_reg  <= m1_tt_reg * m1_w_reg;
            m2_fl_reg <= m1_fl_reg;
            ss_s_reg  <= p_rnd[42:28];
            ss_fl_reg <= m2_fl_reg;
        end
    end

    // ------------------------------------------------------------------
    // Blend, strength, rounding
    // ------------------------------------------------------------------
    logic                l1_v_reg, l2_v_reg, sp_v_reg;
    logic signed [16:0]  l1_a_reg;
    logic signed [33:0]  l1_prod_reg;
    logic signed [16:0]  l2_lvl_reg;
    logic signed [33:0]  sp_reg;
    logic signed [20:0]  r_val_reg;
    flags_t              l1_fl_reg, l2_fl_reg, sp_fl_reg, r_fl_reg;
    logic signed [16:0]  lv_a, lv_b;
    logic signed [17:0]  lv_diff;
    logic signed [20:0]  lv_sum;

    always_comb begin
        if (ss_fl_reg.inner) begin
            lv_a = dig_reg ? AIR_LEVEL : SOLID_LEVEL;
            lv_b = lv_a;
        end else if (dig_reg) begin
            lv_a = AIR_LEVEL;
            lv_b = ss_fl_reg.below ? SOLID_LEVEL : '0;
        end else begin
            lv_a = SOLID_LEVEL;
            lv_b = '0;
        end
        lv_diff = 18'(lv_b) - 18'(lv_a);
    end

    assign lv_sum = 21'(l1_a_reg) + rnd14(l1_prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_v_reg <= 1'b0;
            l2_v_reg <= 1'b0;
            sp_v_reg <= 1'b0;
            r_v_reg  <= 1'b0;
        end else if (en) begin
            l1_v_reg <= ss_v_reg;
            l2_v_reg <= l1_v_reg;
            sp_v_reg <= l2_v_reg;
            r_v_reg  <= sp_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l1_a_reg    <= lv_a;
            l1_prod_reg <= 34'(lv_diff) * 34'($signed({1'b0, ss_s_reg}));
            l1_fl_reg   <= ss_fl_reg;
            l2_lvl_reg  <= 17'(lv_sum);
            l2_fl_reg   <= l1_fl_reg;
            sp_reg      <= l2_lvl_reg * $signed({1'b0, strength_reg});
            sp_fl_reg   <= l2_fl_reg;
            r_val_reg   <= rnd14(sp_reg);
            r_fl_reg    <= sp_fl_reg;
        end
    end

    // Clamp to plus or minus one, drop magnitudes of 0.01 or less, and zero items out of bounds.
    logic signed [20:0] cl_val;

    always_comb begin
        if (r_val_reg > SDF_MAX) begin
            cl_val = SDF_MAX;
        end else if (r_val_reg < SDF_MIN) begin
            cl_val = SDF_MIN;
        end else begin
            cl_val = r_val_reg;
        end
        if ((cl_val <= SDF_THRESH && cl_val >= -SDF_THRESH) || !r_fl_reg.inb) begin
            cl_val = '0;
        end
        res_item.sdf_value = 16'(cl_val);
        res_item.in_bounds = r_fl_reg.inb;
    end

endmodule
`default_nettype wire

// ===== sv/sbsdf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbsdf_checker
// Port-level checks of the sphere brush SDF falloff unit, bound to the top.
// ----------------------------------------------------------------------------
`include "sphere_brush_sdf_falloff_unit_assert.svh"

module sbsdf_checker
    import sbsdf_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item
);

    `SBSDF_ASSERT(a_m_valid_holds, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `SBSDF_ASSERT(a_m_item_holds, m_valid && !m_ready |=> $stable(m_item), "stalled result changed")
    `SBSDF_ASSERT(a_outside_zero, m_valid && !m_item.in_bounds |-> m_item.sdf_value == 16'sd0, "nonzero value outside the brush")
    `SBSDF_ASSERT(a_sdf_range, m_valid |-> (m_item.sdf_value == 16'sd0) || (m_item.sdf_value >= 16'sd164 && m_item.sdf_value <= 16'sd16384) || (m_item.sdf_value <= -16'sd164 && m_item.sdf_value >= -16'sd16384), "value outside clamp or threshold")
    `SBSDF_ASSERT_ALWAYS(a_reset_empty, !$past(aresetn) |-> !m_valid, "result shown right after reset")

endmodule

bind sphere_brush_sdf_falloff_unit sbsdf_checker u_sbsdf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sphere brush SDF falloff unit: random and
// directed voxel items, several brush settings, random stalls on both sides.
// ----------------------------------------------------------------------------

class sdf_scoreboard;
    sbsdf_pkg::out_item_t pending_q[$];
    int mismatch_count;

    logic signed [23:0] cx, cy, cz;
    logic [22:0] radius, falloff;
    logic [15:0] strength, voxel;
    logic dig;

    function new();
        mismatch_count = 0;
        cx = 0; cy = 0; cz = 0;
        radius = 23'd256; falloff = 23'd256;
        strength = 16'd16384; dig = 1'b1; voxel = 16'd256;
    endfunction

    function void set_reg(sbsdf_pkg::cfg_reg_e idx, logic [23:0] data);
        case (idx)
            sbsdf_pkg::REG_CENTER_X:       cx = data;
            sbsdf_pkg::REG_CENTER_Y:       cy = data;
            sbsdf_pkg::REG_CENTER_Z:       cz = data;
            sbsdf_pkg::REG_BRUSH_RADIUS:   radius = data[22:0];
            sbsdf_pkg::REG_FALLOFF_WIDTH:  falloff = data[22:0];
            sbsdf_pkg::REG_BRUSH_STRENGTH: strength = data[15:0];
            sbsdf_pkg::REG_DIG_MODE:       dig = data[0];
            sbsdf_pkg::REG_VOXEL_SIZE:     voxel = data[15:0];
            default: ;
        endcase
    endfunction

    // Floor square root by bit-by-bit restoring method.
    function longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Divide by 2^14 with rounding half away from zero.
    function longint round_q14(longint p);
        longint unsigned m;
        longint q;
        m = (p < 0) ? -p : p;
        q = (m + 8192) >> 14;
        return (p < 0) ? -q : q;
    endfunction

    function longint blend(longint a, longint b, longint s);
        return a + round_q14((b - a) * s);
    endfunction

    function void note_voxel(sbsdf_pkg::in_item_t it);
        longint dx, dy, dz, lvl, val, s;
        longint unsigned d2, outer, fade, root_dist, r14, t, num;
        sbsdf_pkg::out_item_t exp_item;
        dx = longint'(it.pos_x) - longint'(cx);
        dy = longint'(it.pos_y) - longint'(cy);
        dz = longint'(it.pos_z) - longint'(cz);
        d2 = dx * dx + dy * dy + dz * dz;
        outer = longint'(radius) + longint'(falloff) + longint'(voxel);
        fade = longint'(falloff) + longint'(voxel);
        val = 0;
        exp_item.in_bounds = (d2 <= outer * outer);
        if (exp_item.in_bounds) begin
            if (d2 <= longint'(radius) * longint'(radius)) begin
                lvl = dig ? 16384 : -16384;
            end else begin
                root_dist = floor_sqrt(d2 << 12);
                r14 = longint'(radius) << 6;
                t = 16384;
                if (fade != 0) begin
                    num = (root_dist > r14) ? root_dist - r14 : 0;
                    t = (num << 14) / (fade << 6);
                    if (t > 16384) t = 16384;
                end
                s = (t * t * (49152 - 2 * t) + (64'd1 << 27)) >> 28;
                if (dig)
                    lvl = (it.pos_z < it.terrain_height) ? blend(16384, -16384, s)
                                                         : blend(16384, 0, s);
                else
                    lvl = blend(-16384, 0, s);
            end
            val = round_q14(lvl * longint'(strength));
            if (val > 16384) val = 16384;
            if (val < -16384) val = -16384;
            if (val <= 163 && val >= -163) val = 0;
        end
        exp_item.sdf_value = val[15:0];
        pending_q.push_back(exp_item);
    endfunction

    function void check_result(sbsdf_pkg::out_item_t got);
        sbsdf_pkg::out_item_t want;
        if (pending_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Unexpected result item: sdf=%0d inb=%0b", got.sdf_value,
                         got.in_bounds);
            return;
        end
        want = pending_q.pop_front();
        if (got.sdf_value !== want.sdf_value || got.in_bounds !== want.in_bounds) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Mismatch: expected sdf=%0d inb=%0b, got sdf=%0d inb=%0b",
                         want.sdf_value, want.in_bounds, got.sdf_value, got.in_bounds);
        end
    endfunction
endclass

module tb_top;
    import sbsdf_pkg::*;

    localparam int LATENCY = 61;
    localparam int WATCHDOG_LIMIT = 5000;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    in_item_t s_item;
    out_item_t m_item;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sdf_scoreboard board;
    int idle_cycles;
    bit hold_off_req;

    sphere_brush_sdf_falloff_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    initial begin
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0; s_item = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        hold_off_req = 1'b0;
    end

    // Scoreboard updates and watchdog at each edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_voxel(s_item);
            if (m_valid && m_ready) board.check_result(m_item);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired");
                $display("** sphere_brush_sdf_falloff_unit: FAILED **");
                $finish;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

    // Receiver: random stalls, one long hold-off on request.
    initial begin : receiver
        int gap;
        int held;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                for (held = 0; held < 300; held++) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    // After each write cfg_valid goes low again before the task returns, so each write is driven once.
    task automatic write_reg(cfg_reg_e idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk iff cfg_ready);
        board.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_voxel(in_item_t it, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk iff s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic logic signed [23:0] rand24();
        return 24'($urandom);
    endfunction

    // Position near the centre so most items land in or near the brush.
    function automatic in_item_t near_voxel(int span);
        in_item_t it;
        it.pos_x = board.cx + 24'($signed($urandom_range(0, 2 * span)) - span);
        it.pos_y = board.cy + 24'($signed($urandom_range(0, 2 * span)) - span);
        it.pos_z = board.cz + 24'($signed($urandom_range(0, 2 * span)) - span);
        it.terrain_height = board.cz + 24'($signed($urandom_range(0, 2 * span)) - span);
        return it;
    endfunction

    task automatic random_phase(int count, int span, bit streaming);
        in_item_t it;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                it = {rand24(), rand24(), rand24(), rand24()};
            end else begin
                it = near_voxel(span);
            end
            send_voxel(it, streaming || ($urandom_range(0, 3) == 0));
        end
    endtask

    initial begin : stimulus
        in_item_t it;
        int span;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items on reset settings: centre, radius edges, band, extremes.
        send_voxel('{24'sd0, 24'sd0, 24'sd0, 24'sd0}, 0);
        send_voxel('{24'sd256, 24'sd0, 24'sd0, 24'sd0}, 0);
        send_voxel('{24'sd257, 24'sd0, 24'sd0, 24'sd0}, 0);
        send_voxel('{24'sd384, 24'sd0, 24'sd0, 24'sd512}, 0);
        send_voxel('{24'sd0, 24'sd0, -24'sd384, 24'sd0}, 0);
        send_voxel('{24'sd0, 24'sd0, 24'sd384, -24'sd8388608}, 0);
        send_voxel('{24'sd768, 24'sd0, 24'sd0, 24'sd0}, 0);
        send_voxel('{24'sd769, 24'sd0, 24'sd0, 24'sd0}, 0);
        send_voxel('{24'sd8388607, 24'sd8388607, 24'sd8388607, 24'sd8388607}, 0);
        send_voxel('{-24'sd8388608, -24'sd8388608, -24'sd8388608, -24'sd8388608}, 0);
        send_voxel('{24'sd300, 24'sd300, 24'sd0, 24'sd8388607}, 0);
        drain();

        // Fill mode with zero fade range: the band is empty.
        write_reg(REG_DIG_MODE, 24'd0);
        write_reg(REG_FALLOFF_WIDTH, 24'd0);
        write_reg(REG_VOXEL_SIZE, 24'd0);
        write_reg(REG_BRUSH_STRENGTH, 24'hFFFF);
        send_voxel('{24'sd256, 24'sd0, 24'sd0, 24'sd0}, 0);
        send_voxel('{24'sd257, 24'sd0, 24'sd0, 24'sd0}, 0);
        send_voxel('{24'sd0, 24'sd0, 24'sd0, 24'sd0}, 0);
        drain();

        // Zero radius, weak strength, off-centre brush at the extremes.
        write_reg(REG_BRUSH_RADIUS, 24'd0);
        write_reg(REG_VOXEL_SIZE, 24'd1);
        write_reg(REG_FALLOFF_WIDTH, 24'd1000);
        write_reg(REG_BRUSH_STRENGTH, 24'd200);
        write_reg(REG_CENTER_X, 24'h7FFFFF);
        write_reg(REG_CENTER_Y, 24'h800000);
        write_reg(REG_CENTER_Z, 24'h000100);
        send_voxel('{24'sd8388607, -24'sd8388608, 24'sd256, 24'sd0}, 0);
        send_voxel('{24'sd8388000, -24'sd8388000, 24'sd500, 24'sd0}, 0);
        send_voxel('{24'sd8388607, -24'sd8388608, 24'sd1256, 24'sd0}, 0);
        drain();

        // Back to dig mode with a medium brush; long receiver hold-off here.
        write_reg(REG_DIG_MODE, 24'd1);
        write_reg(REG_BRUSH_RADIUS, 24'd2000);
        write_reg(REG_FALLOFF_WIDTH, 24'd1500);
        write_reg(REG_VOXEL_SIZE, 24'd256);
        write_reg(REG_BRUSH_STRENGTH, 24'd20000);
        write_reg(REG_CENTER_X, 24'hFFF000);
        write_reg(REG_CENTER_Y, 24'd4096);
        write_reg(REG_CENTER_Z, 24'd0);
        hold_off_req = 1'b1;
        random_phase(150, 4000, 1);
        drain();

        random_phase(150, 4000, 0);
        drain();

        // Fill mode, large radius near the top of the range.
        write_reg(REG_DIG_MODE, 24'd0);
        write_reg(REG_BRUSH_RADIUS, 24'h7FFFFF);
        write_reg(REG_FALLOFF_WIDTH, 24'h7FFFFF);
        write_reg(REG_VOXEL_SIZE, 24'hFFFF);
        write_reg(REG_BRUSH_STRENGTH, 24'd8000);
        random_phase(120, 8388607, 0);
        drain();

        // Random settings per phase, with small brushes mostly.
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_DIG_MODE, 24'($urandom_range(0, 1)));
            write_reg(REG_BRUSH_RADIUS, 24'($urandom_range(0, 3000)));
            write_reg(REG_FALLOFF_WIDTH, 24'($urandom_range(0, 3000)));
            write_reg(REG_VOXEL_SIZE, 24'($urandom_range(0, 600)));
            write_reg(REG_BRUSH_STRENGTH, 24'($urandom_range(0, 65535)));
            write_reg(REG_CENTER_X, rand24());
            write_reg(REG_CENTER_Y, rand24());
            write_reg(REG_CENTER_Z, rand24());
            span = 2 * (board.radius + board.falloff + board.voxel) + 16;
            random_phase(60, span, p[0]);
            drain();
        end

        if (board.mismatch_count == 0 && board.pending_q.size() == 0) begin
            $display("** sphere_brush_sdf_falloff_unit: PASSED **");
        end else begin
            $display("** sphere_brush_sdf_falloff_unit: FAILED **");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/sbsdf_pkg.sv
sv/sphere_brush_sdf_falloff_unit.sv
sv/sbsdf_checker.sv
tb/tb_top.sv
